FILE: hw/rtl/refcounted_block_pool_unit_defines.svh
// Assertion macros shared by the block pool RTL.
// Every macro samples on clk and is switched off while rst_n is low.
`ifndef REFCOUNTED_BLOCK_POOL_UNIT_DEFINES_SVH
`define REFCOUNTED_BLOCK_POOL_UNIT_DEFINES_SVH

// The condition must hold at every clock edge.
`define RBP_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// When the trigger holds, the condition must hold in the next cycle.
`define RBP_ASSERT_NEXT(lbl, trig, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

FILE: hw/rtl/rbp_pkg.sv
`timescale 1ns / 1ps

package rbp_pkg;

    // Default pool capacity and the pool size taken at reset.
    localparam int NUM_BLOCKS_DEF = 64;
    localparam int POOL_RESET_DEF = 64;

    // Field widths of the requests, results and the size register.
    localparam int OP_W     = 2;
    localparam int BIDX_W   = 6;
    localparam int STATUS_W = 2;
    localparam int REF_W    = 8;
    localparam int USE_W    = 7;
    localparam int POOL_W   = 7;

    localparam int IN_W  = 8;
    localparam int OUT_W = 32;

    localparam logic [REF_W-1:0] REF_MAX = '1;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC   = 2'd0,
        OP_ADDREF  = 2'd1,
        OP_RELEASE = 2'd2,
        OP_UNSHARE = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_BAD   = 2'd2,
        ST_SAT   = 2'd3
    } rbp_status_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear_step;
        logic rd_en;
        logic commit;
        logic second_wr;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_last;
        logic need_second;
    } sts_t;

endpackage

FILE: hw/rtl/rbp_ctrl.sv
`timescale 1ns / 1ps
`include "refcounted_block_pool_unit_defines.svh"

module rbp_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic          s_tvalid,
    output logic          s_tready,
    output logic          m_tvalid,
    input  logic          m_tready,
    input  rbp_pkg::sts_t sts,
    output rbp_pkg::cmd_t cmd
);
    import rbp_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_EXEC  = 4'b0100,
        S_UNSH  = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   slot_free;

    assign slot_free = !out_valid_reg || m_tready;
    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (sts.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (slot_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = sts.need_second ? S_UNSH : S_IDLE;
                end
            end
            S_UNSH:
            begin
                cmd.second_wr = 1'b1;
                state_next    = S_IDLE;
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
        // A size write restarts the initialisation sweep.
        if (cfg_we)
        begin
            cmd        = '0;
            state_next = S_CLEAR;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `RBP_ASSERT_NEXT(a_accept_exec, s_tvalid && s_tready && !cfg_we,
        state_reg == S_EXEC, "accepted request did not reach execution")
    `RBP_ASSERT_NEXT(a_second_write, cmd.commit && sts.need_second && !cfg_we,
        state_reg == S_UNSH, "unshare copy missed its second count write")
    `RBP_ASSERT_NEXT(a_commit_valid, cmd.commit && !cfg_we, m_tvalid,
        "committed result not presented")

endmodule

FILE: hw/rtl/rbp_dpath.sv
`timescale 1ns / 1ps
`include "refcounted_block_pool_unit_defines.svh"

module rbp_dpath #(
    parameter int NUM_BLOCKS = rbp_pkg::NUM_BLOCKS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [rbp_pkg::POOL_W-1:0] cfg_data,
    input  logic [rbp_pkg::IN_W-1:0]   in_data,
    input  rbp_pkg::cmd_t              cmd,
    output rbp_pkg::sts_t              sts,
    output logic [rbp_pkg::OUT_W-1:0]  out_data
);
    import rbp_pkg::*;

    localparam int IDX_W     = $clog2(NUM_BLOCKS);
    localparam int CNT_W     = $clog2(NUM_BLOCKS + 1);
    localparam int POOL_INIT = (POOL_RESET_DEF > NUM_BLOCKS) ? NUM_BLOCKS : POOL_RESET_DEF;

    // Count and free stack storage.
    logic [REF_W-1:0] ref_mem   [NUM_BLOCKS];
    logic [IDX_W-1:0] stack_mem [NUM_BLOCKS];

    logic [CNT_W-1:0]  pool_reg, free_reg, used_reg, peak_reg;
    logic [CNT_W-1:0]  free_next, used_next, peak_next;
    logic [IDX_W-1:0]  clr_reg;
    op_t               op_reg;
    logic [BIDX_W-1:0] bi_reg;
    logic [REF_W-1:0]  ref_rd_reg;
    logic [IDX_W-1:0]  top_rd_reg;

    logic [STATUS_W-1:0] st_reg;
    logic [BIDX_W-1:0]   res_reg;
    logic [REF_W-1:0]    ra_reg;
    logic [USE_W-1:0]    use_reg, peak_out_reg;

    logic [31:0]       cfg_clamped;
    logic [CNT_W-1:0]  pool_cfg;
    logic [BIDX_W-1:0] bi_in;
    logic [IDX_W-1:0]  top_addr;

    rbp_status_t       st;
    logic [BIDX_W-1:0] res;
    logic [REF_W-1:0]  ra;
    logic              in_range, valid, can_pop;
    logic              do_pop, do_push;
    logic              need_second;
    logic              exec_we;
    logic [IDX_W-1:0]  exec_wa;
    logic [REF_W-1:0]  exec_wd;

    logic              ref_we, stk_we;
    logic [IDX_W-1:0]  ref_wa, stk_wa;
    logic [REF_W-1:0]  ref_wd;
    logic [IDX_W-1:0]  stk_wd;

    // Pool size is clamped into one to the capacity.
    always_comb
    begin
        cfg_clamped = 32'(cfg_data);
        if (cfg_data == '0)
        begin
            cfg_clamped = 32'd1;
        end
        else if (32'(cfg_data) > 32'(NUM_BLOCKS))
        begin
            cfg_clamped = 32'(NUM_BLOCKS);
        end
        pool_cfg = CNT_W'(cfg_clamped);
    end

    assign bi_in    = in_data[OP_W +: BIDX_W];
    assign top_addr = IDX_W'(free_reg - CNT_W'(1));

    assign sts = '{clear_last:  (32'(clr_reg) == 32'(pool_reg) - 32'd1),
                   need_second: need_second};

    // Outcome of the latched request.
    always_comb
    begin
        in_range = 32'(bi_reg) < 32'(pool_reg);
        valid    = in_range && (ref_rd_reg != '0);
        can_pop  = (free_reg != '0);
        st       = ST_OK;
        res      = bi_reg;
        ra       = '0;
        do_pop   = 1'b0;
        do_push  = 1'b0;
        exec_we  = 1'b0;
        exec_wa  = IDX_W'(bi_reg);
        exec_wd  = '0;
        need_second = 1'b0;
        if (op_reg == OP_ALLOC)
        begin
            res = '0;
            if (can_pop)
            begin
                do_pop  = 1'b1;
                res     = BIDX_W'(top_rd_reg);
                ra      = REF_W'(1);
                exec_we = 1'b1;
                exec_wa = top_rd_reg;
                exec_wd = REF_W'(1);
            end
            else
            begin
                st = ST_EMPTY;
            end
        end
        else if (!valid)
        begin
            st = ST_BAD;
        end
        else
        begin
            case (op_reg)
                OP_ADDREF:
                begin
                    if (ref_rd_reg == REF_MAX)
                    begin
                        st = ST_SAT;
                        ra = REF_MAX;
                    end
                    else
                    begin
                        ra      = ref_rd_reg + REF_W'(1);
                        exec_we = 1'b1;
                        exec_wd = ra;
                    end
                end
                OP_RELEASE:
                begin
                    exec_we = 1'b1;
                    if (ref_rd_reg > REF_W'(1))
                    begin
                        ra      = ref_rd_reg - REF_W'(1);
                        exec_wd = ra;
                    end
                    else
                    begin
                        do_push = 1'b1;
                    end
                end
                OP_UNSHARE:
                begin
                    ra = ref_rd_reg;
                    if (ref_rd_reg > REF_W'(1))
                    begin
                        if (can_pop)
                        begin
                            do_pop      = 1'b1;
                            res         = BIDX_W'(top_rd_reg);
                            ra          = REF_W'(1);
                            exec_we     = 1'b1;
                            exec_wd     = ref_rd_reg - REF_W'(1);
                            need_second = 1'b1;
                        end
                        else
                        begin
                            st = ST_EMPTY;
                        end
                    end
                end
                default:
                begin
                    st = ST_BAD;
                end
            endcase
        end

        free_next = free_reg;
        used_next = used_reg;
        if (do_pop)
        begin
            free_next = free_reg - CNT_W'(1);
            used_next = used_reg + CNT_W'(1);
        end
        else if (do_push)
        begin
            free_next = free_reg + CNT_W'(1);
            if (used_reg != '0)
            begin
                used_next = used_reg - CNT_W'(1);
            end
        end
        peak_next = (used_next > peak_reg) ? used_next : peak_reg;
    end

    // Single write port per memory, shared by the sweep and the operations.
    always_comb
    begin
        ref_we = 1'b0;
        ref_wa = clr_reg;
        ref_wd = '0;
        stk_we = 1'b0;
        stk_wa = clr_reg;
        stk_wd = IDX_W'(pool_reg - CNT_W'(1) - CNT_W'(clr_reg));
        if (cmd.clear_step)
        begin
            ref_we = 1'b1;
            stk_we = 1'b1;
        end
        else if (cmd.commit)
        begin
            ref_we = exec_we;
            ref_wa = exec_wa;
            ref_wd = exec_wd;
            stk_we = do_push;
            stk_wa = IDX_W'(free_reg);
            stk_wd = IDX_W'(bi_reg);
        end
        else if (cmd.second_wr)
        begin
            ref_we = 1'b1;
            ref_wa = top_rd_reg;
            ref_wd = REF_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ref_we)
        begin
            ref_mem[ref_wa] <= ref_wd;
        end
        if (cmd.rd_en)
        begin
            ref_rd_reg <= ref_mem[IDX_W'(bi_in)];
        end
    end

    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stack_mem[stk_wa] <= stk_wd;
        end
        if (cmd.rd_en)
        begin
            top_rd_reg <= stack_mem[top_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            op_reg <= op_t'(in_data[OP_W-1:0]);
            bi_reg <= bi_in;
        end
        if (cmd.commit)
        begin
            st_reg       <= st;
            res_reg      <= res;
            ra_reg       <= ra;
            use_reg      <= USE_W'(used_next);
            peak_out_reg <= USE_W'(peak_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_reg <= CNT_W'(POOL_INIT);
            free_reg <= CNT_W'(POOL_INIT);
            used_reg <= '0;
            peak_reg <= '0;
            clr_reg  <= '0;
        end
        else if (cfg_we)
        begin
            pool_reg <= pool_cfg;
            free_reg <= pool_cfg;
            used_reg <= '0;
            peak_reg <= '0;
            clr_reg  <= '0;
        end
        else if (cmd.clear_step)
        begin
            clr_reg <= clr_reg + IDX_W'(1);
        end
        else if (cmd.commit)
        begin
            free_reg <= free_next;
            used_reg <= used_next;
            peak_reg <= peak_next;
        end
    end

    assign out_data = {{(OUT_W - STATUS_W - BIDX_W - REF_W - 2 * USE_W){1'b0}},
                       peak_out_reg, use_reg, ra_reg, res_reg, st_reg};

    `RBP_ASSERT_ALWAYS(a_block_balance,
        32'(free_reg) + 32'(used_reg) == 32'(pool_reg),
        "free and used buffers do not add up to the pool size")
    `RBP_ASSERT_ALWAYS(a_peak_bound, peak_reg >= used_reg,
        "peak fell below the buffers in use")
    `RBP_ASSERT_NEXT(a_alloc_count, cmd.commit && do_pop && !cfg_we,
        used_reg == $past(used_reg) + CNT_W'(1), "allocation did not raise the use count")

endmodule

FILE: hw/rtl/refcounted_block_pool_unit.sv
`timescale 1ns / 1ps
// Reference-counted buffer pool with a LIFO free stack.
// Requests arrive on the s_t* channel, each carrying an opcode (allocate, add
// reference, release, unshare) and a buffer index. Every request produces one
// result on the m_t* channel: a status, the buffer to use, its reference count
// afterwards, and the buffers in use together with their peak.
// A request is accepted in the idle state and moves to execution in the following
// cycle, where it executes once the output register is free; its result is then
// registered for the m_t* channel. An unshare that hands out a copy also passes
// through S_UNSH for its second count write, since the count memory has one write
// port. The next request is accepted only once execution is complete.
// The result sits in an output register, so a stalled receiver does not stop
// the next request being taken; that request then waits in execution until
// the held result has been taken.
// After reset, and after every write of pool_size on cfg_we/cfg_data, the
// block sweeps its memories once, one entry per cycle, over pool size entries
// (at most NUM_BLOCKS), to clear the counts and refill the free stack with the
// lowest index on top; s_tready stays low during the sweep.
module refcounted_block_pool_unit #(
    parameter int NUM_BLOCKS = rbp_pkg::NUM_BLOCKS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    // Pool size register, written whenever cfg_we is high.
    input  logic                       cfg_we,
    input  logic [rbp_pkg::POOL_W-1:0] cfg_data,
    // Request channel.
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [rbp_pkg::IN_W-1:0]   s_tdata,   // opcode[1:0], block_index[7:2]
    // Result channel.
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [rbp_pkg::OUT_W-1:0]  m_tdata    // status[1:0], result_index[7:2],
                                                  // ref_after[15:8], in_use[22:16],
                                                  // in_use_peak[29:23], zero[31:30]
);
    import rbp_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // The controller sequences the sweep, request capture and execution.
    rbp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // The datapath holds the count and stack memories, the counters and the
    // result register.
    rbp_dpath #(
        .NUM_BLOCKS (NUM_BLOCKS)
    ) u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .in_data  (s_tdata),
        .cmd      (cmd),
        .sts      (sts),
        .out_data (m_tdata)
    );

endmodule
